### hdl/swfr_pkg.sv
`default_nettype none
package swfr_pkg;

  // Line bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // Control field codes
  localparam logic [7:0] C_SET  = 8'h03;
  localparam logic [7:0] C_UA   = 8'h07;
  localparam logic [7:0] C_DISC = 8'h0B;
  localparam logic [7:0] C_I0   = 8'h00;
  localparam logic [7:0] C_I1   = 8'h40;
  localparam logic [7:0] C_RR0  = 8'h05;
  localparam logic [7:0] C_RR1  = 8'h85;
  localparam logic [7:0] C_REJ0 = 8'h01;
  localparam logic [7:0] C_REJ1 = 8'h81;

  localparam logic [7:0] ADDR_RESET = 8'h03;

  typedef enum logic [2:0] {
    FS_START,
    FS_FLAG,
    FS_ADDR,
    FS_CTRL,
    FS_DATA,
    FS_TAIL
  } frame_state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CONN,
    PH_WAITUA
  } link_phase_t;

  typedef enum logic [1:0] {
    K_DATA  = 2'd0,
    K_RESP  = 2'd1,
    K_EVENT = 2'd2
  } out_kind_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_OPENED     = 3'd1,
    EV_ACCEPTED   = 3'd2,
    EV_BAD_CHECK  = 3'd3,
    EV_DUPLICATE  = 3'd4,
    EV_DISCONNECT = 3'd5,
    EV_CLOSED     = 3'd6,
    EV_BAD_ESCAPE = 3'd7
  } event_t;

  // Work item handed from the deframer to the result sequencer
  typedef enum logic [1:0] {
    OP_DATA,        // one payload byte
    OP_EVENT,       // one event, no response frame
    OP_EVENT_RESP   // event followed by a five-byte response frame
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;  // payload byte, or response control field
    event_t     ev;
  } cmd_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam int STEP_W = 3;

endpackage
`default_nettype wire

### hdl/swfr_front.sv
`default_nettype none
module swfr_front import swfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] address_byte,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output logic            cmd_push,
  output cmd_t            cmd
);

  frame_state_t fs_r, fs_nxt;
  link_phase_t  phase_r, phase_nxt;
  logic         seq_r, seq_nxt;
  logic [7:0]   ctrl_r, ctrl_nxt;
  logic [7:0]   held_r, held_nxt;
  logic         held_valid_r, held_valid_nxt;
  logic         esc_r, esc_nxt;
  logic [7:0]   check_r, check_nxt;

  logic         ctrl_ok;
  logic         is_flag;
  logic         rx_seq;
  logic         good;
  logic [7:0]   unesc;
  frame_state_t miss_state;

  always_comb begin
    case (phase_r)
      PH_CONN:   ctrl_ok = (rx_byte == C_I0) || (rx_byte == C_I1) || (rx_byte == C_DISC);
      PH_WAITUA: ctrl_ok = (rx_byte == C_UA);
      default:   ctrl_ok = (rx_byte == C_SET);
    endcase
  end

  assign is_flag    = (rx_byte == FLAG_BYTE);
  assign miss_state = is_flag ? FS_FLAG : FS_START;
  assign rx_seq     = (ctrl_r == C_I1);
  assign good       = held_valid_r && (check_r == held_r);
  assign unesc      = esc_r ? (rx_byte ^ ESC_XOR) : rx_byte;

  always_comb begin
    fs_nxt         = fs_r;
    phase_nxt      = phase_r;
    seq_nxt        = seq_r;
    ctrl_nxt       = ctrl_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    esc_nxt        = esc_r;
    check_nxt      = check_r;
    cmd_push       = 1'b0;
    cmd            = '{op: OP_DATA, data: 8'h00, ev: EV_NONE};
    if (accept) begin
      case (fs_r)
        FS_FLAG: begin
          if (rx_byte == address_byte) begin
            fs_nxt = FS_ADDR;
          end else if (!is_flag) begin
            fs_nxt = FS_START;
          end
        end
        FS_ADDR: begin
          if (ctrl_ok) begin
            ctrl_nxt = rx_byte;
            fs_nxt   = FS_CTRL;
          end else begin
            fs_nxt = miss_state;
          end
        end
        FS_CTRL: begin
          // BCC1 compare wins over the flag test
          if (rx_byte == (address_byte ^ ctrl_r)) begin
            if ((ctrl_r == C_I0) || (ctrl_r == C_I1)) begin
              fs_nxt         = FS_DATA;
              held_valid_nxt = 1'b0;
              held_nxt       = 8'h00;
              esc_nxt        = 1'b0;
              check_nxt      = 8'h00;
            end else begin
              fs_nxt = FS_TAIL;
            end
          end else begin
            fs_nxt = miss_state;
          end
        end
        FS_TAIL: begin
          if (is_flag) begin
            fs_nxt   = FS_FLAG;
            cmd_push = 1'b1;
            if (ctrl_r == C_SET) begin
              phase_nxt = PH_CONN;
              seq_nxt   = 1'b0;
              cmd       = '{op: OP_EVENT_RESP, data: C_UA, ev: EV_OPENED};
            end else if (ctrl_r == C_DISC) begin
              phase_nxt = PH_WAITUA;
              cmd       = '{op: OP_EVENT_RESP, data: C_DISC, ev: EV_DISCONNECT};
            end else begin
              phase_nxt = PH_IDLE;
              cmd       = '{op: OP_EVENT, data: 8'h00, ev: EV_CLOSED};
            end
          end else begin
            fs_nxt = FS_START;
          end
        end
        FS_DATA: begin
          if (is_flag) begin
            cmd_push = 1'b1;
            esc_nxt  = 1'b0;
            fs_nxt   = FS_FLAG;
            if (esc_r) begin
              cmd = '{op: OP_EVENT, data: 8'h00, ev: EV_BAD_ESCAPE};
            end else if (rx_seq != seq_r) begin
              cmd = '{op: OP_EVENT_RESP, data: (seq_r ? C_RR1 : C_RR0), ev: EV_DUPLICATE};
            end else if (good) begin
              seq_nxt = ~seq_r;
              cmd = '{op: OP_EVENT_RESP, data: (seq_r ? C_RR0 : C_RR1), ev: EV_ACCEPTED};
            end else begin
              cmd = '{op: OP_EVENT_RESP, data: (seq_r ? C_REJ1 : C_REJ0),
                      ev: EV_BAD_CHECK};
            end
          end else if (!esc_r && (rx_byte == ESC_BYTE)) begin
            esc_nxt = 1'b1;
          end else begin
            esc_nxt = 1'b0;
            // previous byte is now known not to be BCC2
            if (held_valid_r) begin
              cmd_push  = 1'b1;
              cmd       = '{op: OP_DATA, data: held_r, ev: EV_NONE};
              check_nxt = check_r ^ held_r;
            end
            held_nxt       = unesc;
            held_valid_nxt = 1'b1;
          end
        end
        default: begin
          fs_nxt = miss_state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r         <= FS_START;
      phase_r      <= PH_IDLE;
      seq_r        <= 1'b0;
      ctrl_r       <= 8'h00;
      held_r       <= 8'h00;
      held_valid_r <= 1'b0;
      esc_r        <= 1'b0;
      check_r      <= 8'h00;
    end else begin
      fs_r         <= fs_nxt;
      phase_r      <= phase_nxt;
      seq_r        <= seq_nxt;
      ctrl_r       <= ctrl_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      esc_r        <= esc_nxt;
      check_r      <= check_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/swfr_cmd_queue.sv
`default_nettype none
module swfr_cmd_queue import swfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/swfr_back.sv
`default_nettype none
module swfr_back import swfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] address_byte,
  input  wire cmd_t       head,
  input  wire logic       empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_event_code,
  output logic            out_last
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              valid_r, valid_nxt;
  out_kind_t         kind_r, kind_c;
  logic [7:0]        byte_r, byte_c;
  event_t            ev_r, ev_c;
  logic              last_r, last_c;
  logic              load;

  assign load = !empty && (!valid_r || out_ready);
  assign pop  = load && last_c;

  // result for the current step of the head command
  always_comb begin
    kind_c = K_RESP;
    byte_c = FLAG_BYTE;
    ev_c   = EV_NONE;
    last_c = 1'b0;
    case (head.op)
      OP_DATA: begin
        kind_c = K_DATA;
        byte_c = head.data;
        last_c = 1'b1;
      end
      OP_EVENT: begin
        kind_c = K_EVENT;
        byte_c = 8'h00;
        ev_c   = head.ev;
        last_c = 1'b1;
      end
      OP_EVENT_RESP: begin
        case (step_r)
          3'd0: begin
            kind_c = K_EVENT;
            byte_c = 8'h00;
            ev_c   = head.ev;
          end
          3'd1:    byte_c = FLAG_BYTE;
          3'd2:    byte_c = address_byte;
          3'd3:    byte_c = head.data;
          3'd4:    byte_c = address_byte ^ head.data;
          default: begin
            byte_c = FLAG_BYTE;
            last_c = 1'b1;
          end
        endcase
      end
      default: begin
        kind_c = K_DATA;
        byte_c = head.data;
        last_c = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (load) begin
      step_nxt  = last_c ? '0 : step_r + 1'b1;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_c;
      byte_r <= byte_c;
      ev_r   <= ev_c;
      last_r <= last_c;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_byte       = byte_r;
  assign out_event_code = ev_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

### hdl/stop_and_wait_frame_receiver.sv
// Receiving side of a stop-and-wait serial link. Feed one line byte per in_ transfer;
// the block deframes FLAG/A/C/BCC1 headers, unescapes payload and streams payload bytes
// out one byte late (tentative until the closing flag checks BCC2), then reports a frame
// event followed, where the protocol calls for one, by a five-byte response frame
// (FLAG, A, C, A^C, FLAG). out_last marks the final result of each input byte; payload of
// a frame reported as bad check, duplicate or bad escape is to be discarded by the user.
// Rate: an input byte is taken every cycle while the four-entry command queue between
// the deframer and the result sequencer has room; the result side drains one result per
// cycle while out_ready is high, so a payload byte yields one result and a frame close
// with response yields six. Sustained rate is set by the output side.
// Register 0 (byte address 0): address_byte, bits [7:0], reset 0x03.
`default_nettype none
module stop_and_wait_frame_receiver import swfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // line byte input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_event_code,
  output logic             out_last,
  // APB-style configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [7:0] addr_r, addr_nxt;
  logic       cfg_wr;
  logic       accept;
  logic       cmd_push;
  cmd_t       cmd;
  cmd_t       head;
  logic       q_empty;
  logic       q_full;
  logic       q_pop;

  // config register: written on the access phase of an APB write
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 3'd0);
  assign addr_nxt   = cfg_wr ? cfg_pwdata[7:0] : addr_r;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {24'h000000, addr_r} : 32'h00000000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  // every input byte yields at most one queue entry, so room for one is enough
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // front: deframer, link state, sequence tracking
  swfr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .address_byte (addr_r),
    .accept       (accept),
    .rx_byte      (in_rx_byte),
    .cmd_push     (cmd_push),
    .cmd          (cmd)
  );

  swfr_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: expands each command into result transfers through an output register
  swfr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .address_byte   (addr_r),
    .head           (head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_event_code (out_event_code),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

### hdl/swfr_checker.sv
`default_nettype none
module swfr_checker import swfr_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] out_event_code,
  input wire logic       out_last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_event_code) && $stable(out_last))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == K_DATA) || (out_kind == K_RESP) || (out_kind == K_EVENT))
    else $error("bad result kind");

  a_event_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_EVENT) |-> (out_byte == 8'h00) && !(out_event_code == EV_NONE))
    else $error("event result malformed");

  a_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(out_kind == K_EVENT) |-> (out_event_code == EV_NONE))
    else $error("event code on byte result");

  // a payload byte is the only result of its input byte
  a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_DATA) |-> out_last)
    else $error("payload byte not last");

endmodule

bind stop_and_wait_frame_receiver swfr_checker u_swfr_checker (.*);
`default_nettype wire

### tb/tb_stop_and_wait_frame_receiver.sv
`default_nettype none
module tb_stop_and_wait_frame_receiver;
  import swfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  // nothing transfers for this long -> the block is stuck
  // (must exceed the long result hold and the worst random stall per result)
  localparam int STALL_LIMIT = 2000;
  // quiet cycles after the last result before touching the register
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 35;
  localparam int REPORT_PRINT_MAX = 40;

  // byte address of register 0 (address_byte)
  localparam logic [2:0] ADDR_REG_OFFSET = 3'd0;

  // how a generated I-frame is damaged, if at all
  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CHECK,
    FRAME_EMPTY,
    FRAME_BAD_ESCAPE
  } frame_fault_t;

  typedef struct {
    out_kind_t  kind;
    logic [7:0] data;
    event_t     ev;
    logic       last;
  } rx_result_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [2:0]  out_event_code;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // line bytes waiting to be driven, results still owed by the block
  logic [7:0] line_q[$];
  rx_result_t due_results[$];
  rx_result_t step_out[$];
  logic [7:0] payload_q[$];

  // predicted receiver state
  frame_state_t fs;
  link_phase_t  ph;
  logic         exp_seq;
  logic [7:0]   ctl;
  logic [7:0]   held;
  logic         held_ok;
  logic         esc;
  logic [7:0]   chk;
  logic [7:0]   addr_reg;

  // stimulus generator's view of the link (can drift after noise)
  link_phase_t gen_phase;
  logic        gen_seq;
  logic [7:0]  gen_addr;

  // run control
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   ready_left = 0;
  int   gap_left = 0;
  int   stall_cycles = 0;

  // bookkeeping
  int pushed_total = 0;
  int n_accepted = 0;
  int n_payload = 0;
  int n_response = 0;
  int n_events = 0;
  int n_settings = 0;
  int err_cnt = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  stop_and_wait_frame_receiver i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_event_code (out_event_code),
    .out_last       (out_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= REPORT_PRINT_MAX) $display("ERROR %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver prediction
  // ---------------------------------------------------------------------------
  function automatic void add_result(input out_kind_t k, input logic [7:0] d, input event_t e);
    rx_result_t r;
    r.kind = k;
    r.data = d;
    r.ev   = e;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  // five-byte answer frame: FLAG, A, C, A^C, FLAG
  function automatic void add_response(input logic [7:0] c);
    add_result(K_RESP, FLAG_BYTE, EV_NONE);
    add_result(K_RESP, addr_reg, EV_NONE);
    add_result(K_RESP, c, EV_NONE);
    add_result(K_RESP, addr_reg ^ c, EV_NONE);
    add_result(K_RESP, FLAG_BYTE, EV_NONE);
  endfunction

  // one line byte in, owed results appended to due_results
  function automatic void deframe_byte(input logic [7:0] b);
    rx_result_t r;
    logic       ctl_ok;
    logic       seq;
    logic       good;
    logic [7:0] v;
    step_out.delete();
    case (fs)
      FS_FLAG: begin
        // address is tested before the flag, so address 0x7e wins
        if (b == addr_reg) fs = FS_ADDR;
        else if (b != FLAG_BYTE) fs = FS_START;
      end
      FS_ADDR: begin
        case (ph)
          PH_CONN:   ctl_ok = (b == C_I0) || (b == C_I1) || (b == C_DISC);
          PH_WAITUA: ctl_ok = (b == C_UA);
          default:   ctl_ok = (b == C_SET);
        endcase
        if (ctl_ok) begin
          ctl = b;
          fs = FS_CTRL;
        end else begin
          fs = (b == FLAG_BYTE) ? FS_FLAG : FS_START;
        end
      end
      FS_CTRL: begin
        // BCC1 match takes precedence over the flag test
        if (b == (addr_reg ^ ctl)) begin
          if (ctl == C_I0 || ctl == C_I1) begin
            fs = FS_DATA;
            held_ok = 1'b0;
            held = 8'h00;
            esc = 1'b0;
            chk = 8'h00;
          end else begin
            fs = FS_TAIL;
          end
        end else begin
          fs = (b == FLAG_BYTE) ? FS_FLAG : FS_START;
        end
      end
      FS_TAIL: begin
        if (b == FLAG_BYTE) begin
          if (ctl == C_SET) begin
            ph = PH_CONN;
            exp_seq = 1'b0;
            add_result(K_EVENT, 8'h00, EV_OPENED);
            add_response(C_UA);
          end else if (ctl == C_DISC) begin
            ph = PH_WAITUA;
            add_result(K_EVENT, 8'h00, EV_DISCONNECT);
            add_response(C_DISC);
          end else begin
            ph = PH_IDLE;
            add_result(K_EVENT, 8'h00, EV_CLOSED);
          end
          fs = FS_FLAG;
        end else begin
          fs = FS_START;
        end
      end
      FS_DATA: begin
        if (b == FLAG_BYTE) begin
          if (esc) begin
            add_result(K_EVENT, 8'h00, EV_BAD_ESCAPE);
          end else begin
            seq = (ctl == C_I1);
            // the held byte is the BCC2 candidate
            good = held_ok && (chk == held);
            if (seq == exp_seq) begin
              if (good) begin
                exp_seq = ~exp_seq;
                add_result(K_EVENT, 8'h00, EV_ACCEPTED);
                add_response(exp_seq ? C_RR1 : C_RR0);
              end else begin
                add_result(K_EVENT, 8'h00, EV_BAD_CHECK);
                add_response(exp_seq ? C_REJ1 : C_REJ0);
              end
            end else begin
              add_result(K_EVENT, 8'h00, EV_DUPLICATE);
              add_response(exp_seq ? C_RR1 : C_RR0);
            end
          end
          esc = 1'b0;
          fs = FS_FLAG;
        end else if (!esc && b == ESC_BYTE) begin
          esc = 1'b1;
        end else begin
          v = esc ? (b ^ ESC_XOR) : b;
          esc = 1'b0;
          if (held_ok) begin
            add_result(K_DATA, held, EV_NONE);
            chk ^= held;
          end
          held = v;
          held_ok = 1'b1;
        end
      end
      default: fs = (b == FLAG_BYTE) ? FS_FLAG : FS_START;
    endcase
    if (step_out.size() != 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
    while (step_out.size() != 0) due_results.push_back(step_out.pop_front());
  endfunction

  // ---------------------------------------------------------------------------
  // Line byte generation
  // ---------------------------------------------------------------------------
  function automatic void push_line(input logic [7:0] b);
    line_q.push_back(b);
    pushed_total++;
  endfunction

  // stuff one payload byte; 0x5d always goes out as 7d 7d, other bytes are
  // escaped now and then, never as 7d 7e
  function automatic void push_data(input logic [7:0] v);
    if (v == FLAG_BYTE || v == ESC_BYTE || v == (ESC_BYTE ^ ESC_XOR) ||
        ($urandom_range(0, 7) == 0 && (v ^ ESC_XOR) != FLAG_BYTE)) begin
      push_line(ESC_BYTE);
      push_line(v ^ ESC_XOR);
    end else begin
      push_line(v);
    end
  endfunction

  // header and closing flag; the opening flag is the previous closing one
  function automatic void queue_super(input logic [7:0] c);
    push_line(gen_addr);
    push_line(c);
    push_line(gen_addr ^ c);
    push_line(FLAG_BYTE);
  endfunction

  // I-frame carrying payload_q, which is consumed
  function automatic void queue_iframe(input logic seq, input frame_fault_t fault);
    logic [7:0] c;
    logic [7:0] bcc;
    c = seq ? C_I1 : C_I0;
    push_line(gen_addr);
    push_line(c);
    push_line(gen_addr ^ c);
    bcc = 8'h00;
    if (fault != FRAME_EMPTY) begin
      foreach (payload_q[i]) begin
        push_data(payload_q[i]);
        bcc ^= payload_q[i];
      end
      if (fault == FRAME_BAD_ESCAPE) push_line(ESC_BYTE);
      else if (fault == FRAME_BAD_CHECK) push_data(bcc ^ 8'($urandom_range(1, 255)));
      else push_data(bcc);
    end
    push_line(FLAG_BYTE);
    payload_q.delete();
  endfunction

  // broken sequences, each closed by a flag to resync the hunt
  function automatic void queue_broken();
    logic [7:0] c;
    logic [7:0] g;
    int         n;
    case (gen_phase)
      PH_CONN:   c = C_DISC;
      PH_WAITUA: c = C_UA;
      default:   c = C_SET;
    endcase
    case ($urandom_range(0, 3))
      0: begin
        n = $urandom_range(1, 4);
        repeat (n) push_line(8'($urandom()));
      end
      1: begin
        // wrong BCC1
        push_line(gen_addr);
        push_line(c);
        push_line(gen_addr ^ c ^ 8'($urandom_range(1, 255)));
      end
      2: begin
        // supervisory header with junk before the flag: silently dropped
        g = 8'($urandom());
        if (g == FLAG_BYTE) g = 8'h00;
        push_line(gen_addr);
        push_line(c);
        push_line(gen_addr ^ c);
        push_line(g);
      end
      default: begin
        push_line(gen_addr);
        push_line(8'($urandom()));
        push_line(8'($urandom()));
      end
    endcase
    push_line(FLAG_BYTE);
  endfunction

  // mostly well-formed link sessions with random payload, plus noise
  task automatic random_session(input int target);
    int base;
    int r;
    int k;
    base = pushed_total;
    while (pushed_total - base < target) begin
      payload_q.delete();
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      repeat (k) begin
        case ($urandom_range(0, 9))
          0:       payload_q.push_back(FLAG_BYTE);
          1:       payload_q.push_back(ESC_BYTE);
          2:       payload_q.push_back(8'h00);
          3:       payload_q.push_back(8'hff);
          default: payload_q.push_back(8'($urandom()));
        endcase
      end
      r = $urandom_range(0, 99);
      case (gen_phase)
        PH_CONN: begin
          if (r < 60) begin
            queue_iframe(gen_seq, FRAME_GOOD);
            gen_seq = ~gen_seq;
          end else if (r < 68) begin
            // duplicate, good or bad
            queue_iframe(~gen_seq, $urandom_range(0, 1) ? FRAME_GOOD : FRAME_BAD_CHECK);
          end else if (r < 75) begin
            queue_iframe(gen_seq, FRAME_BAD_CHECK);
          end else if (r < 79) begin
            queue_iframe(gen_seq, FRAME_EMPTY);
          end else if (r < 83) begin
            queue_iframe(gen_seq, FRAME_BAD_ESCAPE);
          end else if (r < 94) begin
            queue_broken();
          end else begin
            queue_super(C_DISC);
            gen_phase = PH_WAITUA;
          end
        end
        PH_WAITUA: begin
          if (r < 70) begin
            queue_super(C_UA);
            gen_phase = PH_IDLE;
          end else if (r < 85) begin
            // I-frame while disconnecting: header rejected
            queue_iframe(gen_seq, FRAME_GOOD);
          end else begin
            queue_broken();
          end
        end
        default: begin
          if (r < 75) begin
            queue_super(C_SET);
            gen_phase = PH_CONN;
            gen_seq = 1'b0;
          end else begin
            queue_broken();
          end
        end
      endcase
    end
    payload_q.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port and phase control
  // ---------------------------------------------------------------------------
  // write address_byte, then read it back
  task automatic set_address(input logic [7:0] v);
    logic [31:0] rd;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_REG_OFFSET;
    cfg_pwdata  <= {24'h0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // write lands on this edge
    addr_reg = v;
    gen_addr = v;
    n_settings++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== {24'h0, v})
      report_mismatch($sformatf("address_byte readback %08h, wrote %02h", rd, v));
  endtask

  // every byte taken, every result seen, then let the pipe settle
  task automatic wait_idle();
    while (n_accepted != pushed_total || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    fs = FS_START;
    ph = PH_IDLE;
    exp_seq = 1'b0;
    ctl = 8'h00;
    held = 8'h00;
    held_ok = 1'b0;
    esc = 1'b0;
    chk = 8'h00;
    addr_reg = ADDR_RESET;
    gen_addr = ADDR_RESET;
    gen_phase = PH_IDLE;
    gen_seq = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a full session at the reset address covering each close case
    set_address(ADDR_RESET);
    push_line(FLAG_BYTE);
    queue_super(C_SET);                     // opened, UA
    payload_q.push_back(FLAG_BYTE);         // both stuffed bytes in payload
    payload_q.push_back(ESC_BYTE);
    queue_iframe(1'b0, FRAME_GOOD);         // accepted, RR1
    queue_iframe(1'b0, FRAME_GOOD);         // resent seq 0 -> duplicate
    queue_iframe(1'b1, FRAME_EMPTY);        // no BCC2 at all -> bad check
    queue_iframe(1'b1, FRAME_BAD_ESCAPE);   // escape right before the flag
    queue_super(C_DISC);                    // disconnect, DISC echoed
    queue_super(C_UA);                      // closed, no answer
    wait_idle();

    // Random sessions, one address setting each; extremes and a flag-valued
    // address first. One phase holds the result side off for a long time,
    // the last one runs without any idling.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       set_address(8'h00);
        1:       set_address(8'hff);
        2:       set_address(FLAG_BYTE);
        default: set_address(8'($urandom()));
      endcase
      gen_phase = ph;
      gen_seq = exp_seq;
      if (fs != FS_FLAG) push_line(FLAG_BYTE);
      if (p == 3) hold_req <= 1'b1;
      if (p == 6) calm <= 1'b1;
      random_session(PHASE_BYTES);
      wait_idle();
    end

    $display("Covered %0d line bytes and %0d results (%0d payload, %0d response, %0d event)",
             n_accepted, n_payload + n_response + n_events, n_payload, n_response, n_events);
    $display("over %0d address settings, with one %0d-cycle result hold", n_settings,
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("PASS stop_and_wait_frame_receiver");
    end else begin
      $display("FAIL stop_and_wait_frame_receiver");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line byte driver: predicts on each accepted transfer, idles in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'h00;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte);
        n_accepted++;
      end
      // slot is free once the current byte went in (or none was offered)
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (line_q.size() != 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= line_q.pop_front();
          if (!calm && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side backpressure: random bursts, one long hold on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_left <= 0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      // block fills its queue and must stall in_ready
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (out_ready && $urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      ready_left <= $urandom_range(0, 14);
    end else begin
      out_ready  <= 1'b1;
      ready_left <= $urandom_range(0, 30);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each transfer against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: kind %0d byte %02h event %0d last %0b",
                                  out_kind, out_byte, out_event_code, out_last));
      end else begin
        want = due_results.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
        if (out_byte !== want.data)
          report_mismatch($sformatf("byte %02h, want %02h", out_byte, want.data));
        if (out_event_code !== want.ev)
          report_mismatch($sformatf("event %0d, want %0d", out_event_code, want.ev));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
        case (want.kind)
          K_DATA:  n_payload++;
          K_RESP:  n_response++;
          default: n_events++;
        endcase
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results still owed", STALL_LIMIT,
               due_results.size());
      $display("FAIL stop_and_wait_frame_receiver");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
`default_nettype wire
